### hw/rtl/kcl_pkg.sv
package kcl_pkg;

   // Result event codes
   typedef enum logic [2:0] {
      EV_STORED    = 3'd0,
      EV_CORRECT   = 3'd1,
      EV_INCORRECT = 3'd2,
      EV_UPDATED   = 3'd3,
      EV_MASTER    = 3'd4,
      EV_CLEARED   = 3'd5
   } event_type;

   // Key codes
   localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [3:0] KEY_STAR       = 4'd10;
   localparam logic [3:0] KEY_HASH       = 4'd11;

   // Stored value of the zero key
   localparam logic [3:0] DIGIT_TEN = 4'd10;

   // Master code after reset
   localparam logic [15:0] MASTER_RESET = 16'h2222;

   // Register index decode (byte address bit 2 and up)
   localparam logic REG_MASTER_CODE = 1'b0;

   typedef struct packed {
      logic green;
      logic middle;
      logic red;
   } lamp_type;

   localparam lamp_type LAMPS_OFF = '{green: 1'b0, middle: 1'b0, red: 1'b0};
   localparam lamp_type LAMPS_ALL = '{green: 1'b1, middle: 1'b1, red: 1'b1};
   localparam lamp_type LAMP_RED  = '{green: 1'b0, middle: 1'b0, red: 1'b1};
   localparam lamp_type LAMP_GRN  = '{green: 1'b1, middle: 1'b0, red: 1'b0};

   typedef struct packed {
      logic     change;
      lamp_type lamps;
   } ctrl_type;

endpackage

### hw/rtl/kcl_step.sv
module kcl_step #(
   parameter int CODE_DIGITS = 4
) (
   input  logic [3:0]                       key_code,
   input  logic [4*CODE_DIGITS-1:0]         slots,
   input  logic [$clog2(CODE_DIGITS+1)-1:0] fill,
   input  logic [4*CODE_DIGITS-1:0]         user_code,
   input  kcl_pkg::ctrl_type                ctrl,
   input  logic [15:0]                      master_code,
   output logic [4*CODE_DIGITS-1:0]         slots_next,
   output logic [$clog2(CODE_DIGITS+1)-1:0] fill_next,
   output logic [4*CODE_DIGITS-1:0]         user_next,
   output kcl_pkg::ctrl_type                ctrl_next,
   output kcl_pkg::event_type               event_res
);
   import kcl_pkg::*;

   localparam int SLOT_W = 4 * CODE_DIGITS;
   localparam int FILL_W = $clog2(CODE_DIGITS + 1);

   logic [SLOT_W-1:0] master_ext;
   logic [SLOT_W-1:0] slots_add;
   logic [FILL_W-1:0] fill_add;
   logic [3:0]        digit;

   // Master digits beyond the fourth read as zero
   assign master_ext = SLOT_W'(master_code);
   assign digit      = (key_code == 4'd0) ? DIGIT_TEN : key_code;

   always_comb begin
      slots_add  = slots;
      fill_add   = fill;
      slots_next = slots;
      fill_next  = fill;
      user_next  = user_code;
      ctrl_next  = ctrl;
      event_res  = EV_STORED;
      if (key_code inside {KEY_STAR, KEY_HASH}) begin
         // Clear keys empty the entry and drop change mode
         slots_next = '0;
         fill_next  = '0;
         ctrl_next  = '{change: 1'b0, lamps: LAMPS_OFF};
         event_res  = EV_CLEARED;
      end else begin
         // Store a digit in the next free slot
         if (key_code <= KEY_LAST_DIGIT && fill < FILL_W'(CODE_DIGITS)) begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
               if (fill == FILL_W'(i)) begin
                  slots_add[4*i +: 4] = digit;
               end
            end
            fill_add = fill + FILL_W'(1);
         end
         slots_next = slots_add;
         fill_next  = fill_add;
         // Check a full entry
         if (fill_add >= FILL_W'(CODE_DIGITS)) begin
            if (slots_add == master_ext) begin
               ctrl_next  = '{change: 1'b1, lamps: LAMPS_ALL};
               slots_next = '0;
               fill_next  = '0;
               event_res  = EV_MASTER;
            end else if (ctrl.change) begin
               user_next  = slots_add;
               ctrl_next  = '{change: 1'b0, lamps: LAMPS_OFF};
               slots_next = '0;
               fill_next  = '0;
               event_res  = EV_UPDATED;
            end else if (slots_add == user_code) begin
               ctrl_next.lamps = LAMP_GRN;
               event_res       = EV_CORRECT;
            end else begin
               ctrl_next.lamps = LAMP_RED;
               event_res       = EV_INCORRECT;
            end
         end
      end
   end

endmodule

### hw/rtl/keypad_code_lock.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_key_code
// rsp_      out        rsp_valid/rsp_stall  event, count, digits, lamps, change mode
// csr_      in/out     APB psel/penable     master_code at byte address 0
//
// One key per cycle while the result side does not stall; a key passes through
// the input register, then the result register, before its result appears.
// The state update is one compare and select pass between the two registers.
// Reset is synchronous; it empties the entry, sets every user code digit to one
// and loads master code 0x2222.
// A stalled result holds the input register; req_stall rises only while it is full.
module keypad_code_lock #(
   parameter int CODE_DIGITS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_key_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output kcl_pkg::event_type rsp_event_res,
   output logic [2:0]         rsp_entry_count,
   output logic [15:0]        rsp_entered_digits,
   output logic               rsp_led_wrong,
   output logic               rsp_led_middle,
   output logic               rsp_led_right,
   output logic               rsp_change_mode,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import kcl_pkg::*;

   localparam int SLOT_W = 4 * CODE_DIGITS;
   localparam int FILL_W = $clog2(CODE_DIGITS + 1);

   logic              in_valid_ff;
   logic [3:0]        in_key_ff;
   logic              out_valid_ff;
   event_type         out_event_ff;
   logic [2:0]        out_count_ff;
   logic [15:0]       out_digits_ff;
   ctrl_type          out_ctrl_ff;

   logic [SLOT_W-1:0] slots_ff, slots_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SLOT_W-1:0] user_ff, user_in;
   ctrl_type          ctrl_ff, ctrl_in;
   logic [15:0]       master_ff;
   event_type         event_in;

   logic advance;
   logic req_take;
   logic csr_write;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_MASTER_CODE);
   assign csr_prdata = (csr_paddr[2] == REG_MASTER_CODE) ? {16'd0, master_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_RESET;
      end else if (csr_write) begin
         master_ff <= csr_pwdata[15:0];
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_key_ff <= req_key_code;
      end
   end

   kcl_step #(
      .CODE_DIGITS(CODE_DIGITS)
   ) u_step (
      .key_code   (in_key_ff),
      .slots      (slots_ff),
      .fill       (fill_ff),
      .user_code  (user_ff),
      .ctrl       (ctrl_ff),
      .master_code(master_ff),
      .slots_next (slots_in),
      .fill_next  (fill_in),
      .user_next  (user_in),
      .ctrl_next  (ctrl_in),
      .event_res  (event_in)
   );

   // Lock state: advance when the key moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= '0;
         fill_ff  <= '0;
         user_ff  <= {CODE_DIGITS{4'd1}};
         ctrl_ff  <= '{change: 1'b0, lamps: LAMPS_OFF};
      end else if (in_valid_ff && advance) begin
         slots_ff <= slots_in;
         fill_ff  <= fill_in;
         user_ff  <= user_in;
         ctrl_ff  <= ctrl_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         out_event_ff  <= event_in;
         out_count_ff  <= 3'(fill_in);
         out_digits_ff <= 16'(slots_in);
         out_ctrl_ff   <= ctrl_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_res      = out_event_ff;
   assign rsp_entry_count    = out_count_ff;
   assign rsp_entered_digits = out_digits_ff;
   assign rsp_led_wrong      = out_ctrl_ff.lamps.red;
   assign rsp_led_middle     = out_ctrl_ff.lamps.middle;
   assign rsp_led_right      = out_ctrl_ff.lamps.green;
   assign rsp_change_mode    = out_ctrl_ff.change;

   // Entry never holds more digits than it has slots
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CODE_DIGITS))
      else $error("entry fill beyond slot count");

   // Change mode always shows all three lamps
   a_change_lamps: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.change |-> (ctrl_ff.lamps == LAMPS_ALL))
      else $error("change mode without all lamps lit");

   // A key in the input register that may advance lands in the result register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> out_valid_ff)
      else $error("advancing key lost");

   // A cleared result reports an empty entry
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_CLEARED) |->
      (rsp_entry_count == 3'd0 && rsp_entered_digits == 16'd0))
      else $error("cleared result with digits held");

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
   import kcl_pkg::*;

   localparam int CODE_LEN = 4;
   localparam int HOLD_LEN = 60;
   localparam logic [2:0] MASTER_ADDR = {REG_MASTER_CODE, 2'b00};

   typedef struct packed {
      event_type   ev;
      logic [2:0]  count;
      logic [15:0] digits;
      logic        wrong;
      logic        middle;
      logic        right;
      logic        change;
   } lock_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_key_code;
   logic        rsp_valid;
   logic        rsp_stall;
   event_type   rsp_event_res;
   logic [2:0]  rsp_entry_count;
   logic [15:0] rsp_entered_digits;
   logic        rsp_led_wrong;
   logic        rsp_led_middle;
   logic        rsp_led_right;
   logic        rsp_change_mode;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // lock model state
   logic [15:0] entry_model;
   logic [2:0]  fill_model;
   logic [15:0] user_model;
   logic        change_model;
   lamp_type    lamps_model;
   logic [15:0] master_model;

   lock_result_type pending_results[$];
   bit              failed;

   // idling controls, written by the test sequence only
   bit tx_idle_on;
   bit rx_idle_on;
   int hold_ticket;

   keypad_code_lock DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key_code       (req_key_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_entered_digits (rsp_entered_digits),
      .rsp_led_wrong      (rsp_led_wrong),
      .rsp_led_middle     (rsp_led_middle),
      .rsp_led_right      (rsp_led_right),
      .rsp_change_mode    (rsp_change_mode),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Give up after a generous bound on the slowest legal run
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   // Advance the lock model by one key and queue the result it predicts
   task automatic predict_key(input logic [3:0] key);
      lock_result_type res;
      event_type       ev;
      ev = EV_STORED;
      if (key == KEY_STAR || key == KEY_HASH) begin
         entry_model  = '0;
         fill_model   = '0;
         lamps_model  = LAMPS_OFF;
         change_model = 1'b0;
         ev = EV_CLEARED;
      end else begin
         if (key <= KEY_LAST_DIGIT && fill_model < CODE_LEN) begin
            entry_model[4*fill_model +: 4] = (key == 4'd0) ? DIGIT_TEN : key;
            fill_model = fill_model + 3'd1;
         end
         if (fill_model >= CODE_LEN) begin
            if (entry_model == master_model) begin
               change_model = 1'b1;
               lamps_model  = LAMPS_ALL;
               entry_model  = '0;
               fill_model   = '0;
               ev = EV_MASTER;
            end else if (change_model) begin
               user_model   = entry_model;
               change_model = 1'b0;
               lamps_model  = LAMPS_OFF;
               entry_model  = '0;
               fill_model   = '0;
               ev = EV_UPDATED;
            end else if (entry_model == user_model) begin
               lamps_model = LAMP_GRN;
               ev = EV_CORRECT;
            end else begin
               lamps_model = LAMP_RED;
               ev = EV_INCORRECT;
            end
         end
      end
      res.ev     = ev;
      res.count  = fill_model;
      res.digits = entry_model;
      res.wrong  = lamps_model.red;
      res.middle = lamps_model.middle;
      res.right  = lamps_model.green;
      res.change = change_model;
      pending_results.push_back(res);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!tx_idle_on || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one key and hold it until the lock takes the transfer
   task automatic send_key(input logic [3:0] key);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_key_code = key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_key(key);
      @(negedge clock);
   endtask

   // Key in a packed four-digit code; digits outside 1..10 become random keys
   task automatic send_code(input logic [15:0] code);
      logic [3:0] d;
      for (int i = 0; i < CODE_LEN; i++) begin
         d = code[4*i +: 4];
         if (d >= 4'd1 && d <= 4'd9)
            send_key(d);
         else if (d == DIGIT_TEN)
            send_key(4'd0);
         else
            send_key(4'($urandom_range(0, 9)));
      end
   endtask

   // Drop valid and wait until every queued result has been taken
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write the master code, then read it back
   task automatic set_master(input logic [15:0] code);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = MASTER_ADDR;
      csr_pwdata  = {16'h0, code};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      master_model = code;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_pwdata  = $urandom;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[15:0] !== master_model) begin
         $display("%0t: master_code read expected %0h got %0h",
                  $time, master_model, csr_prdata[15:0]);
         failed = 1'b1;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic logic [15:0] random_master();
      logic [15:0] code;
      for (int i = 0; i < CODE_LEN; i++)
         code[4*i +: 4] = 4'($urandom_range(1, 10));
      return code;
   endfunction

   // Mostly whole codes (master, user, near-user, random), with clears,
   // unused keys and broken partial entries mixed in
   task automatic send_random_items(input int n);
      int          sent;
      int          r;
      logic [15:0] code;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(0, 99);
         if (r < 80 && fill_model != 0 && $urandom_range(0, 4) != 0) begin
            send_key($urandom_range(0, 1) ? KEY_STAR : KEY_HASH);
            sent++;
         end
         if (r < 30) begin
            send_code(master_model);
            sent += CODE_LEN;
         end else if (r < 55) begin
            code = user_model;
            if ($urandom_range(0, 2) == 0)
               code[4*$urandom_range(0, 3) +: 4] = 4'($urandom_range(1, 10));
            send_code(code);
            sent += CODE_LEN;
         end else if (r < 80) begin
            send_code(16'h0);
            sent += CODE_LEN;
         end else if (r < 87) begin
            send_key($urandom_range(0, 1) ? KEY_STAR : KEY_HASH);
            sent++;
         end else if (r < 92) begin
            send_key(4'($urandom_range(12, 15)));
            sent++;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               send_key(4'($urandom_range(0, 9)));
               sent++;
            end
         end
      end
   endtask

   task automatic test_directed();
      logic [3:0] keys[$];
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      // reset user code, rerun on a full entry, unused keys full and empty,
      // master entry, user code entered in change mode, clear leaves change mode
      keys = '{4'd1, 4'd1, 4'd1, 4'd1, 4'd5, 4'd12, KEY_HASH, 4'd15, 4'd9, 4'd0,
               4'd3, KEY_STAR, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
               4'd2, 4'd2, 4'd2, 4'd2, KEY_STAR, 4'd0, 4'd0, 4'd0, 4'd9, 4'd14,
               KEY_HASH};
      foreach (keys[i])
         send_key(keys[i]);
      drain_results();
   endtask

   task automatic test_master_settings();
      logic [15:0] masters[$];
      masters = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h1111, 16'h0000, random_master()};
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      foreach (masters[i]) begin
         // one setting equal to the current user code
         set_master(i == 4 ? user_model : masters[i]);
         send_random_items(40);
         drain_results();
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 4; phase++) begin
         tx_idle_on = (phase != 1);
         rx_idle_on = (phase != 2);
         set_master(phase == 0 ? MASTER_RESET : random_master());
         send_random_items(135);
         drain_results();
      end
   endtask

   // Hold off the receiver while keys keep coming, so the input stalls
   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b1;
      @(negedge clock);
      hold_ticket++;
      send_random_items(30);
      drain_results();
   endtask

   // Receiver stall: random short and long stretches, plus requested holds
   initial begin : rsp_stall_driver
      int hold_cnt;
      int stall_left;
      int hold_seen;
      hold_cnt   = 0;
      stall_left = 0;
      hold_seen  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_cnt  = HOLD_LEN;
         end
         if (hold_cnt > 0) begin
            rsp_stall = 1'b1;
            hold_cnt--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(9, 24);
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      lock_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none got event %0d",
                     $time, rsp_event_res);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            report_field("event_res", 16'(want.ev), 16'(rsp_event_res));
            report_field("entry_count", 16'(want.count), 16'(rsp_entry_count));
            report_field("entered_digits", want.digits, rsp_entered_digits);
            report_field("led_wrong", 16'(want.wrong), 16'(rsp_led_wrong));
            report_field("led_middle", 16'(want.middle), 16'(rsp_led_middle));
            report_field("led_right", 16'(want.right), 16'(rsp_led_right));
            report_field("change_mode", 16'(want.change), 16'(rsp_change_mode));
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_key_code = 4'd0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      failed       = 1'b0;
      tx_idle_on   = 1'b0;
      rx_idle_on   = 1'b0;
      hold_ticket  = 0;
      entry_model  = '0;
      fill_model   = '0;
      user_model   = 16'h1111;
      change_model = 1'b0;
      lamps_model  = LAMPS_OFF;
      master_model = MASTER_RESET;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_master_settings();
      test_random();
      test_backpressure();

      drain_results();
      repeat (10) @(posedge clock);
      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
